// ----- rtl/core/mhtq_pkg.sv -----
// mhtq_pkg: shared types and codes for the min-heap timer queue
// used by mhtq_ctrl, mhtq_dp, the top level and the checker
package mhtq_pkg;

  localparam int KEY_W     = 32;
  localparam int ID_W      = 5;
  localparam int NUM_IDS   = 32;
  localparam int MAX_FIRED = 32;
  localparam int FIRED_W   = $clog2(MAX_FIRED + 1);

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_CANCEL = 2'd1;
  localparam logic [1:0] REQ_ADJUST = 2'd2;
  localparam logic [1:0] REQ_TICK   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  // result kinds
  localparam logic KIND_FIRED = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  // heap read address selects
  localparam logic [2:0] RD_PARENT = 3'd0;
  localparam logic [2:0] RD_LEFT   = 3'd1;
  localparam logic [2:0] RD_RIGHT  = 3'd2;
  localparam logic [2:0] RD_TOP    = 3'd3;
  localparam logic [2:0] RD_LAST   = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef struct packed {
    logic       cap_in;
    logic       cur_new;
    logic       cur_pos;
    logic       cur_last;
    logic       canc_set;
    logic       canc_clr;
    logic       set_st;
    logic [1:0] st_code;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       wr_final;
    logic       mv_parent;
    logic       mv_child;
    logic       save_left;
    logic       save_right;
    logic       pop;
    logic       fire_clr;
    logic       out_fire;
    logic       out_comp;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       present;
    logic       full;
    logic       cnt_zero;
    logic       slot_zero;
    logic       parent_le;
    logic       left_oob;
    logic       right_oob;
    logic       chosen_lt;
    logic       top_exp;
    logic       live;
    logic       out_free;
    logic       fired_max;
  } sts_t;

endpackage

// ----- rtl/core/min_heap_timer_queue_unit.sv -----
// Min-heap timer queue: up to CAPACITY timers keyed by 32-bit expiry.
// Input channel (in_*): one request item, add / cancel / adjust / tick.
// Result channel (out_*): zero or more fired items, then one completion item
//   with out_last high carrying status, empty flag and the top expiry.
// One request is worked at a time; in_stall is high from acceptance until the
//   completion item is loaded into the result register.
// All request work is set by the heap memory, one read per cycle; a tick's
//   work grows with the timers it pops.
// A tick fires at most 32 timers; expired timers past that wait for the next tick.
// Reset (synchronous, rst_n low) empties the heap, clears all positions and
//   cancel marks; heap memory contents are not cleared and need no sweep.
// A stalled result holds in the output register; the sequencer waits on it
//   only when it has the next result ready.
// Depends on mhtq_pkg, mhtq_ctrl and mhtq_dp.
module min_heap_timer_queue_unit import mhtq_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_req_type,
  input  logic [ID_W-1:0]  in_timer_id,
  input  logic [KEY_W-1:0] in_expire_time,
  input  logic [KEY_W-1:0] in_now_time,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_kind,
  output logic [ID_W-1:0]  out_fired_id,
  output logic [1:0]       out_status,
  output logic             out_heap_empty,
  output logic [KEY_W-1:0] out_next_expire,
  output logic             out_last
);

  cmd_t cmd;
  sts_t sts;

  mhtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mhtq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_req_type     (in_req_type),
    .in_timer_id     (in_timer_id),
    .in_expire_time  (in_expire_time),
    .in_now_time     (in_now_time),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_fired_id    (out_fired_id),
    .out_status      (out_status),
    .out_heap_empty  (out_heap_empty),
    .out_next_expire (out_next_expire),
    .out_last        (out_last)
  );

endmodule

// ----- rtl/core/mhtq_dp.sv -----
// mhtq_dp: heap memory, id position map, cancel marks, work registers, result register
// depends on mhtq_pkg; driven by mhtq_ctrl through cmd_t
module mhtq_dp import mhtq_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       in_req_type,
  input  logic [ID_W-1:0]  in_timer_id,
  input  logic [KEY_W-1:0] in_expire_time,
  input  logic [KEY_W-1:0] in_now_time,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_kind,
  output logic [ID_W-1:0]  out_fired_id,
  output logic [1:0]       out_status,
  output logic             out_heap_empty,
  output logic [KEY_W-1:0] out_next_expire,
  output logic             out_last
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = SW + 2;

  entry_t           heap_mem [CAPACITY];
  logic [SW-1:0]    pos_r [NUM_IDS];
  logic [NUM_IDS-1:0] pos_v_r;
  logic [NUM_IDS-1:0] canc_r;

  logic [1:0]       req_type_r;
  logic [ID_W-1:0]  req_id_r;
  logic [KEY_W-1:0] req_exp_r;
  logic [KEY_W-1:0] req_now_r;
  logic [CW-1:0]    cnt_r;
  logic [SW-1:0]    cur_slot_r;
  logic [KEY_W-1:0] cur_key_r;
  logic [ID_W-1:0]  cur_id_r;
  entry_t           rdata_r;
  entry_t           ch_r;
  logic [SW-1:0]    ch_slot_r;
  logic [ID_W-1:0]  fire_id_r;
  logic             live_r;
  logic [FIRED_W-1:0] fired_r;
  logic [1:0]       st_r;

  logic             out_valid_r;
  logic             out_kind_r;
  logic [ID_W-1:0]  out_id_r;
  logic [1:0]       out_st_r;
  logic             out_empty_r;
  logic [KEY_W-1:0] out_next_r;
  logic             out_last_r;

  logic [SW-1:0]    parent_idx;
  logic [XW-1:0]    left_x;
  logic [XW-1:0]    right_x;
  logic [XW-1:0]    cnt_x;
  logic [SW-1:0]    rd_addr;
  logic [SW-1:0]    pos_q;
  logic             wr_en;
  entry_t           wr_data;

  assign parent_idx = (cur_slot_r - SW'(1)) >> 1;
  assign left_x     = {1'b0, cur_slot_r, 1'b1};
  assign right_x    = left_x + XW'(1);
  assign cnt_x      = XW'(cnt_r);
  assign pos_q      = pos_r[req_id_r];

  always_comb begin
    unique case (cmd.rd_sel)
      RD_PARENT: rd_addr = parent_idx;
      RD_LEFT:   rd_addr = left_x[SW-1:0];
      RD_RIGHT:  rd_addr = right_x[SW-1:0];
      RD_TOP:    rd_addr = '0;
      RD_LAST:   rd_addr = cnt_r[SW-1:0];
      default:   rd_addr = '0;
    endcase
  end

  assign wr_en = cmd.wr_final | cmd.mv_parent | cmd.mv_child;

  always_comb begin
    priority if (cmd.mv_parent) begin
      wr_data = rdata_r;
    end else if (cmd.mv_child) begin
      wr_data = ch_r;
    end else begin
      wr_data = '{key: cur_key_r, id: cur_id_r};
    end
  end

  // heap memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[cur_slot_r] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= heap_mem[rd_addr];
    end
  end

  // every heap write also moves the position of the id written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_r[wr_data.id] <= cur_slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_v_r <= '0;
      canc_r  <= '0;
    end else begin
      if (wr_en) begin
        pos_v_r[wr_data.id] <= 1'b1;
      end
      if (cmd.pop) begin
        pos_v_r[rdata_r.id] <= 1'b0;
        canc_r[rdata_r.id]  <= 1'b0;
      end
      if (cmd.canc_set) begin
        canc_r[req_id_r] <= 1'b1;
      end
      if (cmd.canc_clr) begin
        canc_r[req_id_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      req_type_r <= in_req_type;
      req_id_r   <= in_timer_id;
      req_exp_r  <= in_expire_time;
      req_now_r  <= in_now_time;
    end
    if (cmd.cur_new) begin
      cur_slot_r <= cnt_r[SW-1:0];
      cur_key_r  <= req_exp_r;
      cur_id_r   <= req_id_r;
    end
    if (cmd.cur_pos) begin
      cur_slot_r <= pos_q;
      cur_key_r  <= req_exp_r;
      cur_id_r   <= req_id_r;
    end
    if (cmd.cur_last) begin
      cur_slot_r <= '0;
      cur_key_r  <= rdata_r.key;
      cur_id_r   <= rdata_r.id;
    end
    if (cmd.mv_parent) begin
      cur_slot_r <= parent_idx;
    end
    if (cmd.mv_child) begin
      cur_slot_r <= ch_slot_r;
    end
    if (cmd.save_left) begin
      ch_r      <= rdata_r;
      ch_slot_r <= left_x[SW-1:0];
    end
    if (cmd.save_right && (rdata_r.key < ch_r.key)) begin
      ch_r      <= rdata_r;
      ch_slot_r <= right_x[SW-1:0];
    end
    if (cmd.pop) begin
      fire_id_r <= rdata_r.id;
      live_r    <= !canc_r[rdata_r.id];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      fired_r <= '0;
      st_r    <= ST_OK;
    end else begin
      if (cmd.cur_new) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.pop) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.fire_clr) begin
        fired_r <= '0;
      end else if (cmd.out_fire) begin
        fired_r <= fired_r + FIRED_W'(1);
      end
      if (cmd.cap_in) begin
        st_r <= ST_OK;
      end else if (cmd.set_st) begin
        st_r <= cmd.st_code;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_fire || cmd.out_comp) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_fire) begin
      out_kind_r  <= KIND_FIRED;
      out_id_r    <= fire_id_r;
      out_st_r    <= ST_OK;
      out_empty_r <= 1'b0;
      out_next_r  <= '0;
      out_last_r  <= 1'b0;
    end else if (cmd.out_comp) begin
      out_kind_r  <= KIND_DONE;
      out_id_r    <= '0;
      out_st_r    <= st_r;
      out_empty_r <= (cnt_r == '0);
      out_next_r  <= (cnt_r == '0) ? '0 : rdata_r.key;
      out_last_r  <= 1'b1;
    end
  end

  always_comb begin
    sts.req_type  = req_type_r;
    sts.present   = pos_v_r[req_id_r] && (CW'(pos_q) < cnt_r);
    sts.full      = (cnt_r >= CW'(CAPACITY));
    sts.cnt_zero  = (cnt_r == '0);
    sts.slot_zero = (cur_slot_r == '0);
    sts.parent_le = (rdata_r.key <= cur_key_r);
    sts.left_oob  = (left_x >= cnt_x);
    sts.right_oob = (right_x >= cnt_x);
    sts.chosen_lt = (ch_r.key < cur_key_r);
    sts.top_exp   = (rdata_r.key <= req_now_r);
    sts.live      = live_r;
    sts.out_free  = !out_valid_r || !out_stall;
    sts.fired_max = (fired_r == FIRED_W'(MAX_FIRED));
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_fired_id    = out_id_r;
  assign out_status      = out_st_r;
  assign out_heap_empty  = out_empty_r;
  assign out_next_expire = out_next_r;
  assign out_last        = out_last_r;

endmodule

// ----- rtl/core/mhtq_ctrl.sv -----
// mhtq_ctrl: request sequencer for the timer heap (sift up, sift down, pop loop)
// depends on mhtq_pkg; drives mhtq_dp through cmd_t, reads sts_t
module mhtq_ctrl import mhtq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_UP    = 4'd2;
  localparam logic [3:0] S_UPC   = 4'd3;
  localparam logic [3:0] S_DN    = 4'd4;
  localparam logic [3:0] S_DNL   = 4'd5;
  localparam logic [3:0] S_DNR   = 4'd6;
  localparam logic [3:0] S_DNC   = 4'd7;
  localparam logic [3:0] S_TCHK  = 4'd8;
  localparam logic [3:0] S_TTOP  = 4'd9;
  localparam logic [3:0] S_TFIRE = 4'd10;
  localparam logic [3:0] S_TLAST = 4'd11;
  localparam logic [3:0] S_TLD   = 4'd12;
  localparam logic [3:0] S_COMP  = 4'd13;
  localparam logic [3:0] S_COMPR = 4'd14;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic [3:0] sift_ret;

  assign in_stall = (state_r != S_IDLE);
  // after a sift-down a tick goes on popping, other requests complete
  assign sift_ret = (sts.req_type == REQ_TICK) ? S_TCHK : S_COMP;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.req_type)
          REQ_ADD: begin
            priority if (sts.present) begin
              cmd.canc_clr = 1'b1;
              cmd.cur_pos  = 1'b1;
              state_nxt    = S_UP;
            end else if (sts.full) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = ST_FULL;
              state_nxt   = S_COMP;
            end else begin
              cmd.canc_clr = 1'b1;
              cmd.cur_new  = 1'b1;
              state_nxt    = S_UP;
            end
          end
          REQ_CANCEL: begin
            if (sts.present) begin
              cmd.canc_set = 1'b1;
            end else begin
              cmd.set_st  = 1'b1;
              cmd.st_code = ST_ABSENT;
            end
            state_nxt = S_COMP;
          end
          REQ_ADJUST: begin
            if (sts.present) begin
              cmd.cur_pos = 1'b1;
              state_nxt   = S_UP;
            end else begin
              cmd.set_st  = 1'b1;
              cmd.st_code = ST_ABSENT;
              state_nxt   = S_COMP;
            end
          end
          default: begin
            cmd.fire_clr = 1'b1;
            state_nxt    = S_TCHK;
          end
        endcase
      end
      S_UP: begin
        if (sts.slot_zero) begin
          state_nxt = S_DN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PARENT;
          state_nxt  = S_UPC;
        end
      end
      S_UPC: begin
        if (sts.parent_le) begin
          state_nxt = S_DN;
        end else begin
          cmd.mv_parent = 1'b1;
          state_nxt     = S_UP;
        end
      end
      S_DN: begin
        if (sts.left_oob) begin
          cmd.wr_final = 1'b1;
          state_nxt    = sift_ret;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LEFT;
          state_nxt  = S_DNL;
        end
      end
      S_DNL: begin
        cmd.save_left = 1'b1;
        if (sts.right_oob) begin
          state_nxt = S_DNC;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_RIGHT;
          state_nxt  = S_DNR;
        end
      end
      S_DNR: begin
        cmd.save_right = 1'b1;
        state_nxt      = S_DNC;
      end
      S_DNC: begin
        if (sts.chosen_lt) begin
          cmd.mv_child = 1'b1;
          state_nxt    = S_DN;
        end else begin
          cmd.wr_final = 1'b1;
          state_nxt    = sift_ret;
        end
      end
      S_TCHK: begin
        if (sts.cnt_zero || sts.fired_max) begin
          state_nxt = S_COMP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_TOP;
          state_nxt  = S_TTOP;
        end
      end
      S_TTOP: begin
        if (sts.top_exp) begin
          cmd.pop   = 1'b1;
          state_nxt = S_TFIRE;
        end else begin
          state_nxt = S_COMP;
        end
      end
      S_TFIRE: begin
        if (!sts.live) begin
          state_nxt = S_TLAST;
        end else if (sts.out_free) begin
          cmd.out_fire = 1'b1;
          state_nxt    = S_TLAST;
        end
      end
      S_TLAST: begin
        if (sts.cnt_zero) begin
          state_nxt = S_TCHK;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LAST;
          state_nxt  = S_TLD;
        end
      end
      S_TLD: begin
        cmd.cur_last = 1'b1;
        state_nxt    = S_DN;
      end
      S_COMP: begin
        if (!sts.cnt_zero) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_TOP;
          state_nxt  = S_COMPR;
        end else if (sts.out_free) begin
          cmd.out_comp = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_COMPR: begin
        if (sts.out_free) begin
          cmd.out_comp = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/mhtq_chk.sv -----
// mhtq_chk: port-level checks for min_heap_timer_queue_unit, attached by bind
// depends on mhtq_pkg
module mhtq_chk import mhtq_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_kind,
  input logic [ID_W-1:0]  out_fired_id,
  input logic [1:0]       out_status,
  input logic             out_heap_empty,
  input logic [KEY_W-1:0] out_next_expire,
  input logic             out_last
);

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous request still open");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_fired_id)
      && $stable(out_status) && $stable(out_next_expire) && $stable(out_last))
    else $error("stalled result changed");

  a_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_kind == KIND_DONE)))
    else $error("last flag does not match result kind");

  a_fired_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_FIRED |->
      out_status == ST_OK && !out_heap_empty && out_next_expire == '0)
    else $error("fired item carries completion fields");

  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DONE |->
      out_fired_id == '0 && (!out_heap_empty || out_next_expire == '0))
    else $error("completion item fields inconsistent");

endmodule

bind min_heap_timer_queue_unit mhtq_chk u_mhtq_chk (.*);
